[src/rsni_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rsni_pkg;

  // fixed point and datapath widths
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned RADIUS_W  = 31;
  localparam int unsigned NRM_W     = 29;   // normalized direction, signed
  localparam int unsigned DOT_W     = 64;   // w.n, signed
  localparam int unsigned DD_W      = 58;   // |n|^2
  localparam int unsigned RAD2_W    = 120;  // radicand of the half chord
  localparam int unsigned ROOT_W    = RAD2_W / 2;
  localparam int unsigned NUM_W     = 92;   // |t| * |n_i|
  localparam int unsigned QUO_W     = 37;

  // sphere register indexes
  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_MISS     = 2'd1,
    ST_ZERO_DIR = 2'd2
  } status_e;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [NRM_W-1:0]   nrm_t;

  // items riding along the square root pipeline
  typedef struct packed {
    coord_t [2:0]     o;
    nrm_t [2:0]       n;
    logic [DOT_W-1:0] b;
    logic [DD_W-1:0]  dd;
    status_e          status;
  } sq_side_t;

  // items riding along the divider pipeline
  typedef struct packed {
    coord_t [2:0] o;
    logic [2:0]   neg;
    status_e      status;
  } dv_side_t;

endpackage

`default_nettype wire

[src/rsni_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none

module rsni_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         vld_i,
  input  logic [rsni_pkg::RAD2_W-1:0]  rad_i,
  input  rsni_pkg::sq_side_t           side_i,
  output logic                         vld_o,
  output logic [rsni_pkg::ROOT_W-1:0]  root_o,
  output rsni_pkg::sq_side_t           side_o
);
  import rsni_pkg::*;

  localparam int unsigned REM_W = ROOT_W + 4;

  logic              vld_q  [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [RAD2_W-1:0] rad_q  [ROOT_W];
  sq_side_t          side_q [ROOT_W];

  // one root bit per stage, restoring digit recurrence
  for (genvar j = 0; j < ROOT_W; j++) begin : g_step
    logic              vld_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD2_W-1:0] rad_in;
    sq_side_t          side_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (j == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign rad_in  = rad_q[j-1];
      assign side_in = side_q[j-1];
    end

    assign rem_sh = {rem_in[REM_W-3:0], rad_in[2*(ROOT_W-1-j)+1 -: 2]};
    assign trial  = {2'b00, root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? rem_sh - trial : rem_sh;
        root_q[j] <= {root_in[ROOT_W-2:0], ge};
        rad_q[j]  <= rad_in;
        side_q[j] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[ROOT_W-1];
  assign root_o = root_q[ROOT_W-1];
  assign side_o = side_q[ROOT_W-1];

endmodule

`default_nettype wire

[src/rsni_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module rsni_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [rsni_pkg::NUM_W-1:0]  num_i [3],
  input  logic [rsni_pkg::DD_W-1:0]   dd_i,
  input  rsni_pkg::dv_side_t          side_i,
  output logic                        vld_o,
  output logic [rsni_pkg::QUO_W-1:0]  quo_o [3],
  output logic [rsni_pkg::DD_W-1:0]   rem_o [3],
  output logic [rsni_pkg::DD_W-1:0]   dd_o,
  output rsni_pkg::dv_side_t          side_o
);
  import rsni_pkg::*;

  logic             vld_q  [QUO_W];
  logic [DD_W-1:0]  rem_q  [QUO_W][3];
  logic [QUO_W-1:0] quo_q  [QUO_W][3];
  logic [NUM_W-1:0] num_q  [QUO_W][3];
  logic [DD_W-1:0]  dd_q   [QUO_W];
  dv_side_t         side_q [QUO_W];

  // one quotient bit per stage, three lanes side by side
  for (genvar j = 0; j < QUO_W; j++) begin : g_step
    logic             vld_in;
    logic [DD_W-1:0]  dd_in;
    dv_side_t         side_in;

    if (j == 0) begin : g_first
      assign vld_in  = vld_i;
      assign dd_in   = dd_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[j-1];
      assign dd_in   = dd_q[j-1];
      assign side_in = side_q[j-1];
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [DD_W-1:0]  rem_in;
      logic [QUO_W-1:0] quo_in;
      logic [NUM_W-1:0] num_in;
      logic [DD_W:0]    rem_sh;
      logic             ge;
      logic [DD_W:0]    rem_sub;

      if (j == 0) begin : g_first
        assign rem_in = DD_W'(num_i[l][NUM_W-1:QUO_W]);
        assign quo_in = '0;
        assign num_in = num_i[l];
      end else begin : g_next
        assign rem_in = rem_q[j-1][l];
        assign quo_in = quo_q[j-1][l];
        assign num_in = num_q[j-1][l];
      end

      assign rem_sh  = {rem_in, num_in[QUO_W-1-j]};
      assign ge      = rem_sh >= {1'b0, dd_in};
      assign rem_sub = rem_sh - {1'b0, dd_in};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j][l] <= ge ? rem_sub[DD_W-1:0] : rem_sh[DD_W-1:0];
          quo_q[j][l] <= {quo_in[QUO_W-2:0], ge};
          num_q[j][l] <= num_in;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dd_q[j]   <= dd_in;
        side_q[j] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[QUO_W-1];
  assign dd_o   = dd_q[QUO_W-1];
  assign side_o = side_q[QUO_W-1];

  for (genvar l = 0; l < 3; l++) begin : g_out
    assign quo_o[l] = quo_q[QUO_W-1][l];
    assign rem_o[l] = rem_q[QUO_W-1][l];
  end

endmodule

`default_nettype wire

[src/ray_sphere_near_intersection.sv]
// Near intersection of a ray with a configured sphere: coordinates are signed Q16.16, the radius unsigned Q15.16.
// The direction is normalized by a power of two, the squared centre-to-line
// distance comes from a cross product and is tested against the radius, and
// the nearer crossing point is returned with saturated coordinates; status
// reports a hit, a miss (coordinates zero) or a zero direction (coordinates
// zero). The datapath is a fully pipelined chain of 112 register stages plus
// a two-entry output buffer: one request enters every clock while the buffer
// is not full, and the whole pipeline stalls while it is full. The length is
// set by the 60-stage square root and the 37-stage divider. Sphere registers
// may be written only while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none

module ray_sphere_near_intersection (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] ray_origin_x_i,
  input  logic [31:0] ray_origin_y_i,
  input  logic [31:0] ray_origin_z_i,
  input  logic [31:0] ray_dir_x_i,
  input  logic [31:0] ray_dir_y_i,
  input  logic [31:0] ray_dir_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] hit_x_o,
  output logic [31:0] hit_y_o,
  output logic [31:0] hit_z_o,
  output logic [1:0]  status_o
);
  import rsni_pkg::*;

  typedef struct packed {
    coord_t [2:0] hit;
    status_e      status;
  } out_t;

  localparam logic [RADIUS_W-1:0] RadiusRst = RADIUS_W'(1) << FRAC_BITS;

  logic en;

  // sphere registers
  logic signed [COORD_W-1:0] ctr_q [3];
  logic [RADIUS_W-1:0]       radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q[0] <= '0;
      ctr_q[1] <= '0;
      ctr_q[2] <= '0;
      radius_q <= RadiusRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_CENTER_X: ctr_q[0] <= cfg_data_i;
        REG_CENTER_Y: ctr_q[1] <= cfg_data_i;
        REG_CENTER_Z: ctr_q[2] <= cfg_data_i;
        REG_RADIUS:   radius_q <= cfg_data_i[RADIUS_W-1:0];
        default:      radius_q <= radius_q;
      endcase
    end
  end

  // stage 1: centre offset, direction magnitudes
  logic signed [COORD_W-1:0] in_o [3];
  logic signed [COORD_W-1:0] in_d [3];
  logic [COORD_W-1:0]        in_mag [3];

  assign in_o[0] = ray_origin_x_i;
  assign in_o[1] = ray_origin_y_i;
  assign in_o[2] = ray_origin_z_i;
  assign in_d[0] = ray_dir_x_i;
  assign in_d[1] = ray_dir_y_i;
  assign in_d[2] = ray_dir_z_i;

  for (genvar i = 0; i < 3; i++) begin : g_mag
    assign in_mag[i] = in_d[i][COORD_W-1] ? COORD_W'(-in_d[i]) : in_d[i];
  end

  logic                      s1_vld_q;
  logic signed [COORD_W-1:0] s1_o_q [3];
  logic signed [COORD_W-1:0] s1_d_q [3];
  logic signed [COORD_W:0]   s1_w_q [3];
  logic [COORD_W-1:0]        s1_or_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_o_q[i] <= in_o[i];
        s1_d_q[i] <= in_d[i];
        s1_w_q[i] <= (COORD_W+1)'(ctr_q[i]) - (COORD_W+1)'(in_o[i]);
      end
      s1_or_q <= in_mag[0] | in_mag[1] | in_mag[2];
    end
  end

  // stage 2: leading one of the largest magnitude
  logic [4:0] s2_p_d;

  always_comb begin
    s2_p_d = '0;
    for (int i = 0; i < COORD_W; i++) begin
      if (s1_or_q[i]) s2_p_d = 5'(i);
    end
  end

  logic                      s2_vld_q;
  logic signed [COORD_W-1:0] s2_o_q [3];
  logic signed [COORD_W-1:0] s2_d_q [3];
  logic signed [COORD_W:0]   s2_w_q [3];
  logic [4:0]                s2_p_q;
  logic                      s2_zero_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_o_q    <= s1_o_q;
      s2_d_q    <= s1_d_q;
      s2_w_q    <= s1_w_q;
      s2_p_q    <= s2_p_d;
      s2_zero_q <= s1_or_q == '0;
    end
  end

  // stage 3: scale direction so its largest component sits at bit 27
  logic signed [NRM_W-1:0] s3_n_d [3];

  for (genvar i = 0; i < 3; i++) begin : g_norm
    logic signed [63:0] dw;
    logic signed [63:0] sh;
    assign dw = 64'(s2_d_q[i]);
    assign sh = (s2_p_q <= 5'd27) ? dw <<< (5'd27 - s2_p_q) : dw >>> (s2_p_q - 5'd27);
    assign s3_n_d[i] = sh[NRM_W-1:0];
  end

  logic                      s3_vld_q;
  logic signed [COORD_W-1:0] s3_o_q [3];
  logic signed [COORD_W:0]   s3_w_q [3];
  logic signed [NRM_W-1:0]   s3_n_q [3];
  logic                      s3_zero_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_o_q    <= s2_o_q;
      s3_w_q    <= s2_w_q;
      s3_n_q    <= s3_n_d;
      s3_zero_q <= s2_zero_q;
    end
  end

  // stage 4: cross, dot and norm products
  logic signed [61:0] s4_pa_d [3];
  logic signed [61:0] s4_pb_d [3];
  logic signed [61:0] s4_pd_d [3];
  logic signed [57:0] s4_sq_d [3];
  logic [61:0]        s4_r2_d;

  assign s4_pa_d[0] = s3_w_q[1] * s3_n_q[2];
  assign s4_pb_d[0] = s3_w_q[2] * s3_n_q[1];
  assign s4_pa_d[1] = s3_w_q[2] * s3_n_q[0];
  assign s4_pb_d[1] = s3_w_q[0] * s3_n_q[2];
  assign s4_pa_d[2] = s3_w_q[0] * s3_n_q[1];
  assign s4_pb_d[2] = s3_w_q[1] * s3_n_q[0];
  assign s4_r2_d    = radius_q * radius_q;

  for (genvar i = 0; i < 3; i++) begin : g_dot
    assign s4_pd_d[i] = s3_w_q[i] * s3_n_q[i];
    assign s4_sq_d[i] = s3_n_q[i] * s3_n_q[i];
  end

  logic                      s4_vld_q;
  logic signed [COORD_W-1:0] s4_o_q [3];
  logic signed [NRM_W-1:0]   s4_n_q [3];
  logic                      s4_zero_q;
  logic signed [61:0]        s4_pa_q [3];
  logic signed [61:0]        s4_pb_q [3];
  logic signed [61:0]        s4_pd_q [3];
  logic [56:0]               s4_nn_q [3];
  logic [61:0]               s4_r2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_o_q    <= s3_o_q;
      s4_n_q    <= s3_n_q;
      s4_zero_q <= s3_zero_q;
      s4_pa_q   <= s4_pa_d;
      s4_pb_q   <= s4_pb_d;
      s4_pd_q   <= s4_pd_d;
      s4_r2_q   <= s4_r2_d;
      for (int i = 0; i < 3; i++) s4_nn_q[i] <= s4_sq_d[i][56:0];
    end
  end

  // stage 5: cross product, w.n and |n|^2
  logic                      s5_vld_q;
  logic signed [COORD_W-1:0] s5_o_q [3];
  logic signed [NRM_W-1:0]   s5_n_q [3];
  logic                      s5_zero_q;
  logic signed [62:0]        s5_cr_q [3];
  logic signed [DOT_W-1:0]   s5_b_q;
  logic [DD_W-1:0]           s5_dd_q;
  logic [61:0]               s5_r2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_o_q    <= s4_o_q;
      s5_n_q    <= s4_n_q;
      s5_zero_q <= s4_zero_q;
      s5_r2_q   <= s4_r2_q;
      for (int i = 0; i < 3; i++) s5_cr_q[i] <= 63'(s4_pa_q[i]) - 63'(s4_pb_q[i]);
      s5_b_q  <= DOT_W'(s4_pd_q[0]) + DOT_W'(s4_pd_q[1]) + DOT_W'(s4_pd_q[2]);
      s5_dd_q <= DD_W'(s4_nn_q[0]) + DD_W'(s4_nn_q[1]) + DD_W'(s4_nn_q[2]);
    end
  end

  // stage 6: cross product magnitudes
  logic                      s6_vld_q;
  logic signed [COORD_W-1:0] s6_o_q [3];
  logic signed [NRM_W-1:0]   s6_n_q [3];
  logic                      s6_zero_q;
  logic [61:0]               s6_crm_q [3];
  logic signed [DOT_W-1:0]   s6_b_q;
  logic [DD_W-1:0]           s6_dd_q;
  logic [61:0]               s6_r2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_o_q    <= s5_o_q;
      s6_n_q    <= s5_n_q;
      s6_zero_q <= s5_zero_q;
      s6_b_q    <= s5_b_q;
      s6_dd_q   <= s5_dd_q;
      s6_r2_q   <= s5_r2_q;
      for (int i = 0; i < 3; i++) begin
        s6_crm_q[i] <= s5_cr_q[i][62] ? 62'(-s5_cr_q[i]) : 62'(s5_cr_q[i]);
      end
    end
  end

  // stage 7: partial products of the squares and of R^2 |n|^2
  logic [61:0] s7_hh_d [3];
  logic [61:0] s7_hl_d [3];
  logic [61:0] s7_ll_d [3];

  for (genvar i = 0; i < 3; i++) begin : g_part
    assign s7_hh_d[i] = s6_crm_q[i][61:31] * s6_crm_q[i][61:31];
    assign s7_hl_d[i] = s6_crm_q[i][61:31] * s6_crm_q[i][30:0];
    assign s7_ll_d[i] = s6_crm_q[i][30:0] * s6_crm_q[i][30:0];
  end

  logic                      s7_vld_q;
  logic signed [COORD_W-1:0] s7_o_q [3];
  logic signed [NRM_W-1:0]   s7_n_q [3];
  logic                      s7_zero_q;
  logic signed [DOT_W-1:0]   s7_b_q;
  logic [DD_W-1:0]           s7_dd_q;
  logic [61:0]               s7_hh_q [3];
  logic [61:0]               s7_hl_q [3];
  logic [61:0]               s7_ll_q [3];
  logic [59:0]               s7_rp_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_o_q     <= s6_o_q;
      s7_n_q     <= s6_n_q;
      s7_zero_q  <= s6_zero_q;
      s7_b_q     <= s6_b_q;
      s7_dd_q    <= s6_dd_q;
      s7_hh_q    <= s7_hh_d;
      s7_hl_q    <= s7_hl_d;
      s7_ll_q    <= s7_ll_d;
      s7_rp_q[0] <= s6_r2_q[61:31] * s6_dd_q[57:29];
      s7_rp_q[1] <= s6_r2_q[61:31] * s6_dd_q[28:0];
      s7_rp_q[2] <= s6_r2_q[30:0] * s6_dd_q[57:29];
      s7_rp_q[3] <= s6_r2_q[30:0] * s6_dd_q[28:0];
    end
  end

  // stage 8: assemble squares and R^2 |n|^2
  logic                      s8_vld_q;
  logic signed [COORD_W-1:0] s8_o_q [3];
  logic signed [NRM_W-1:0]   s8_n_q [3];
  logic                      s8_zero_q;
  logic signed [DOT_W-1:0]   s8_b_q;
  logic [DD_W-1:0]           s8_dd_q;
  logic [123:0]              s8_sq_q [3];
  logic [RAD2_W-1:0]         s8_rdd_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_o_q    <= s7_o_q;
      s8_n_q    <= s7_n_q;
      s8_zero_q <= s7_zero_q;
      s8_b_q    <= s7_b_q;
      s8_dd_q   <= s7_dd_q;
      for (int i = 0; i < 3; i++) begin
        s8_sq_q[i] <= (124'(s7_hh_q[i]) << 62) + (124'(s7_hl_q[i]) << 32)
                      + 124'(s7_ll_q[i]);
      end
      s8_rdd_q <= (RAD2_W'(s7_rp_q[0]) << 60) + (RAD2_W'(s7_rp_q[1]) << 31)
                  + (RAD2_W'(s7_rp_q[2]) << 29) + RAD2_W'(s7_rp_q[3]);
    end
  end

  // stage 9: squared distance times |n|^2
  logic                      s9_vld_q;
  logic signed [COORD_W-1:0] s9_o_q [3];
  logic signed [NRM_W-1:0]   s9_n_q [3];
  logic                      s9_zero_q;
  logic signed [DOT_W-1:0]   s9_b_q;
  logic [DD_W-1:0]           s9_dd_q;
  logic [125:0]              s9_cross_q;
  logic [RAD2_W-1:0]         s9_rdd_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s9_o_q     <= s8_o_q;
      s9_n_q     <= s8_n_q;
      s9_zero_q  <= s8_zero_q;
      s9_b_q     <= s8_b_q;
      s9_dd_q    <= s8_dd_q;
      s9_rdd_q   <= s8_rdd_q;
      s9_cross_q <= 126'(s8_sq_q[0]) + 126'(s8_sq_q[1]) + 126'(s8_sq_q[2]);
    end
  end

  // stage 10: hit test and radicand of the half chord
  logic                      s10_vld_q;
  logic signed [COORD_W-1:0] s10_o_q [3];
  logic signed [NRM_W-1:0]   s10_n_q [3];
  logic signed [DOT_W-1:0]   s10_b_q;
  logic [DD_W-1:0]           s10_dd_q;
  logic [RAD2_W-1:0]         s10_rad_q;
  status_e                   s10_status_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s10_o_q   <= s9_o_q;
      s10_n_q   <= s9_n_q;
      s10_b_q   <= s9_b_q;
      s10_dd_q  <= s9_dd_q;
      s10_rad_q <= s9_rdd_q - s9_cross_q[RAD2_W-1:0];
      if (s9_zero_q) begin
        s10_status_q <= ST_ZERO_DIR;
      end else if (s9_cross_q <= 126'(s9_rdd_q)) begin
        s10_status_q <= ST_HIT;
      end else begin
        s10_status_q <= ST_MISS;
      end
    end
  end

  // half chord
  sq_side_t          sq_side_in;
  sq_side_t          sq_side_out;
  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;

  for (genvar i = 0; i < 3; i++) begin : g_sqin
    assign sq_side_in.o[i] = s10_o_q[i];
    assign sq_side_in.n[i] = s10_n_q[i];
  end
  assign sq_side_in.b      = s10_b_q;
  assign sq_side_in.dd     = s10_dd_q;
  assign sq_side_in.status = s10_status_q;

  rsni_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s10_vld_q),
    .rad_i  (s10_rad_q),
    .side_i (sq_side_in),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side_out)
  );

  // stage 11: line parameter of the near point
  logic                    s11_vld_q;
  logic signed [DOT_W-1:0] s11_t_q;
  sq_side_t                s11_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s11_t_q    <= $signed(sq_side_out.b) - $signed(DOT_W'(sq_root));
      s11_side_q <= sq_side_out;
    end
  end

  // stage 12: magnitudes and result signs
  logic                s12_vld_q;
  logic [62:0]         s12_tm_q;
  logic [NRM_W-1:0]    s12_nm_q [3];
  logic [DD_W-1:0]     s12_dd_q;
  dv_side_t            s12_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s12_tm_q <= s11_t_q[DOT_W-1] ? 63'(-s11_t_q) : 63'(s11_t_q);
      s12_dd_q <= s11_side_q.dd;
      for (int i = 0; i < 3; i++) begin
        s12_nm_q[i] <= s11_side_q.n[i][NRM_W-1] ? NRM_W'(-$signed(s11_side_q.n[i]))
                                                : s11_side_q.n[i];
        s12_side_q.o[i]   <= s11_side_q.o[i];
        s12_side_q.neg[i] <= s11_t_q[DOT_W-1] ^ s11_side_q.n[i][NRM_W-1];
      end
      s12_side_q.status <= s11_side_q.status;
    end
  end

  // stage 13: partial products of |t| |n_i|
  logic        s13_vld_q;
  logic [60:0] s13_pl_q [3];
  logic [59:0] s13_ph_q [3];
  logic [DD_W-1:0] s13_dd_q;
  dv_side_t    s13_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s13_pl_q[i] <= s12_tm_q[31:0] * s12_nm_q[i];
        s13_ph_q[i] <= s12_tm_q[62:32] * s12_nm_q[i];
      end
      s13_dd_q   <= s12_dd_q;
      s13_side_q <= s12_side_q;
    end
  end

  // stage 14: dividends
  logic             s14_vld_q;
  logic [NUM_W-1:0] s14_num_q [3];
  logic [DD_W-1:0]  s14_dd_q;
  dv_side_t         s14_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s14_num_q[i] <= (NUM_W'(s13_ph_q[i]) << 32) + NUM_W'(s13_pl_q[i]);
      end
      s14_dd_q   <= s13_dd_q;
      s14_side_q <= s13_side_q;
    end
  end

  // offsets along the direction
  logic             dv_vld;
  logic [QUO_W-1:0] dv_quo [3];
  logic [DD_W-1:0]  dv_rem [3];
  logic [DD_W-1:0]  dv_dd;
  dv_side_t         dv_side;

  rsni_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s14_vld_q),
    .num_i  (s14_num_q),
    .dd_i   (s14_dd_q),
    .side_i (s14_side_q),
    .vld_o  (dv_vld),
    .quo_o  (dv_quo),
    .rem_o  (dv_rem),
    .dd_o   (dv_dd),
    .side_o (dv_side)
  );

  // stage 15: round to nearest, ties away from zero
  logic           s15_vld_q;
  logic [QUO_W:0] s15_q_q [3];
  dv_side_t       s15_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s15_q_q[i] <= (QUO_W+1)'(dv_quo[i])
                      + (QUO_W+1)'({dv_rem[i], 1'b0} >= {1'b0, dv_dd});
      end
      s15_side_q <= dv_side;
    end
  end

  // valid bits of the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      s7_vld_q  <= 1'b0;
      s8_vld_q  <= 1'b0;
      s9_vld_q  <= 1'b0;
      s10_vld_q <= 1'b0;
      s11_vld_q <= 1'b0;
      s12_vld_q <= 1'b0;
      s13_vld_q <= 1'b0;
      s14_vld_q <= 1'b0;
      s15_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= in_valid_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      s6_vld_q  <= s5_vld_q;
      s7_vld_q  <= s6_vld_q;
      s8_vld_q  <= s7_vld_q;
      s9_vld_q  <= s8_vld_q;
      s10_vld_q <= s9_vld_q;
      s11_vld_q <= sq_vld;
      s12_vld_q <= s11_vld_q;
      s13_vld_q <= s12_vld_q;
      s14_vld_q <= s13_vld_q;
      s15_vld_q <= dv_vld;
    end
  end

  // final add with saturation
  out_t res;

  for (genvar i = 0; i < 3; i++) begin : g_fin
    logic signed [39:0] oe;
    logic signed [39:0] qe;
    logic signed [39:0] v;
    logic [COORD_W-1:0] sat;
    assign oe = 40'($signed(s15_side_q.o[i]));
    assign qe = $signed(40'(s15_q_q[i]));
    assign v  = s15_side_q.neg[i] ? oe - qe : oe + qe;
    always_comb begin
      if (v > 40'sd2147483647) begin
        sat = 32'h7fff_ffff;
      end else if (v < -40'sd2147483648) begin
        sat = 32'h8000_0000;
      end else begin
        sat = v[COORD_W-1:0];
      end
    end
    assign res.hit[i] = (s15_side_q.status == ST_HIT) ? sat : '0;
  end
  assign res.status = s15_side_q.status;

  // two-entry output buffer, the pipeline stalls only when it is full
  out_t       obuf_q [2];
  logic       wptr_q;
  logic       rptr_q;
  logic [1:0] ocnt_q;
  logic       push;
  logic       pop;

  assign en   = ocnt_q != 2'd2;
  assign push = s15_vld_q && en;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      ocnt_q <= '0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      ocnt_q <= ocnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) obuf_q[wptr_q] <= res;
  end

  assign in_ready_o  = en;
  assign out_valid_o = ocnt_q != '0;
  assign hit_x_o     = obuf_q[rptr_q].hit[0];
  assign hit_y_o     = obuf_q[rptr_q].hit[1];
  assign hit_z_o     = obuf_q[rptr_q].hit[2];
  assign status_o    = obuf_q[rptr_q].status;

endmodule

`default_nettype wire

[src/rsni_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module rsni_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [1:0]  cfg_idx_i,
  input logic [31:0] cfg_data_i,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [31:0] ray_origin_x_i,
  input logic [31:0] ray_origin_y_i,
  input logic [31:0] ray_origin_z_i,
  input logic [31:0] ray_dir_x_i,
  input logic [31:0] ray_dir_y_i,
  input logic [31:0] ray_dir_z_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] hit_x_o,
  input logic [31:0] hit_y_o,
  input logic [31:0] hit_z_o,
  input logic [1:0]  status_o
);
  import rsni_pkg::*;

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before it was taken");

  // a held result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(hit_x_o) && $stable(hit_y_o)
                                    && $stable(hit_z_o) && $stable(status_o))
    else $error("result changed while stalled");

  // back pressure on requests only comes from a pending result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("request stalled with no result pending");

  // miss and zero direction report the origin of coordinates
  a_nohit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_HIT) |-> hit_x_o == '0 && hit_y_o == '0
                                            && hit_z_o == '0)
    else $error("coordinates set on a result without a hit");

endmodule

bind ray_sphere_near_intersection rsni_checker u_rsni_checker (.*);

`default_nettype wire

[test/near_hit_checker.sv]
`timescale 1ns / 1ps

module near_hit_checker
  import rsni_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] ray_origin_x_i,
  input  logic [31:0] ray_origin_y_i,
  input  logic [31:0] ray_origin_z_i,
  input  logic [31:0] ray_dir_x_i,
  input  logic [31:0] ray_dir_y_i,
  input  logic [31:0] ray_dir_z_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] hit_x_i,
  input  logic [31:0] hit_y_i,
  input  logic [31:0] hit_z_i,
  input  logic [1:0]  status_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    status_e     status;
  } near_hit_t;

  // sphere copy kept by the predictor
  longint          center_q [3];
  longint unsigned radius_q;
  near_hit_t       hit_queue [$];

  function automatic longint unsigned mag(longint x);
    return (x < 0) ? longint'(-x) : x;
  endfunction

  // near intersection of one ray with the current sphere
  function automatic near_hit_t predict_near_hit(logic [31:0] org [3], logic [31:0] dir [3]);
    longint          o [3];
    longint          n [3];
    longint          w [3];
    longint          cr [3];
    longint unsigned m, dd, s, cand;
    longint          b, t, v;
    logic [127:0]    cross2, rdd, rad, c, num, q, rem;
    int              k;
    near_hit_t       r;
    m = 0; dd = 0; b = 0; k = 0; cross2 = '0;
    r = '{x: '0, y: '0, z: '0, status: ST_HIT};
    for (int i = 0; i < 3; i++) begin
      o[i] = longint'(signed'(org[i]));
      n[i] = longint'(signed'(dir[i]));
      if (mag(n[i]) > m) m = mag(n[i]);
    end
    if (m == 0) begin
      r.status = ST_ZERO_DIR;
      return r;
    end
    // bring the largest component into [2^27, 2^28)
    while (m < (64'd1 << 27)) begin
      for (int i = 0; i < 3; i++) n[i] = n[i] * 2;
      m = m * 2;
    end
    while ((m >> k) >= (64'd1 << 28)) k++;
    for (int i = 0; i < 3; i++) n[i] = n[i] >>> k;
    for (int i = 0; i < 3; i++) w[i] = center_q[i] - o[i];
    cr[0] = w[1] * n[2] - w[2] * n[1];
    cr[1] = w[2] * n[0] - w[0] * n[2];
    cr[2] = w[0] * n[1] - w[1] * n[0];
    for (int i = 0; i < 3; i++) begin
      c = 128'(mag(cr[i]));
      cross2 = cross2 + c * c;
      dd = dd + mag(n[i]) * mag(n[i]);
      b = b + w[i] * n[i];
    end
    rdd = 128'(radius_q * radius_q) * 128'(dd);
    if (cross2 > rdd) begin
      r.status = ST_MISS;
      return r;
    end
    // half chord by bitwise square root
    rad = rdd - cross2;
    s = 0;
    for (int bit_i = 62; bit_i >= 0; bit_i--) begin
      cand = s | (64'd1 << bit_i);
      c = 128'(cand);
      if (c * c <= rad) s = cand;
    end
    t = b - longint'(s);
    for (int i = 0; i < 3; i++) begin
      num = 128'(mag(t)) * 128'(mag(n[i]));
      q = num / 128'(dd);
      rem = num % 128'(dd);
      if (2 * rem >= 128'(dd)) q = q + 1;
      v = ((t < 0) != (n[i] < 0)) ? o[i] - longint'(q[63:0]) : o[i] + longint'(q[63:0]);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      case (i)
        0: r.x = v[31:0];
        1: r.y = v[31:0];
        default: r.z = v[31:0];
      endcase
    end
    return r;
  endfunction

  assign pending_o = hit_queue.size();

  // sphere register shadow
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q[0] <= 0;
      center_q[1] <= 0;
      center_q[2] <= 0;
      radius_q <= 64'd1 << FRAC_BITS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CENTER_X: center_q[0] <= longint'(signed'(cfg_data_i));
        REG_CENTER_Y: center_q[1] <= longint'(signed'(cfg_data_i));
        REG_CENTER_Z: center_q[2] <= longint'(signed'(cfg_data_i));
        REG_RADIUS:   radius_q <= 64'(cfg_data_i[30:0]);
        default: ;
      endcase
    end
  end

  // predict on each accepted request, compare each accepted result
  initial fail_count_o = 0;
  always @(posedge clk_i) begin
    logic [31:0] org [3];
    logic [31:0] dir [3];
    near_hit_t   exp_hit;
    int          errs;
    errs = 0;
    if (rst_ni && in_valid_i && in_ready_i) begin
      org = '{ray_origin_x_i, ray_origin_y_i, ray_origin_z_i};
      dir = '{ray_dir_x_i, ray_dir_y_i, ray_dir_z_i};
      hit_queue.push_back(predict_near_hit(org, dir));
    end
    if (rst_ni && out_valid_i && out_ready_i) begin
      if (hit_queue.size() == 0) begin
        $error("result with no request outstanding");
        errs++;
      end else begin
        exp_hit = hit_queue.pop_front();
        if (hit_x_i !== exp_hit.x) begin
          $error("hit_x expected %h actual %h", exp_hit.x, hit_x_i);
          errs++;
        end
        if (hit_y_i !== exp_hit.y) begin
          $error("hit_y expected %h actual %h", exp_hit.y, hit_y_i);
          errs++;
        end
        if (hit_z_i !== exp_hit.z) begin
          $error("hit_z expected %h actual %h", exp_hit.z, hit_z_i);
          errs++;
        end
        if (status_i !== exp_hit.status) begin
          $error("status expected %0d actual %0d", exp_hit.status, status_i);
          errs++;
        end
      end
    end
    if (errs != 0) fail_count_o <= fail_count_o + errs;
  end

endmodule

[test/ray_sphere_near_intersection_test.sv]
`timescale 1ns / 1ps

module ray_sphere_near_intersection_test;
  import rsni_pkg::*;

  localparam longint ONE = 64'sd65536;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] ray_origin_x_i = '0, ray_origin_y_i = '0, ray_origin_z_i = '0;
  logic [31:0] ray_dir_x_i = '0, ray_dir_y_i = '0, ray_dir_z_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] hit_x_o, hit_y_o, hit_z_o;
  logic [1:0]  status_o;
  int          fail_count, pending;

  int          idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_req = 1'b0;
  longint      center [3] = '{0, 0, 0};
  longint      radius = ONE;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  ray_sphere_near_intersection dut (.*);

  near_hit_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o),
    .ray_origin_x_i, .ray_origin_y_i, .ray_origin_z_i,
    .ray_dir_x_i, .ray_dir_y_i, .ray_dir_z_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .hit_x_i(hit_x_o), .hit_y_i(hit_y_o), .hit_z_i(hit_z_o), .status_i(status_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        for (int i = 0; i < 400; i++) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_ready_i = ($urandom_range(99) >= stall_pct);
    end
  end

  // safety limit
  initial begin
    #5ms;
    $display("ray_sphere_near_intersection test failed");
    $finish;
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_CENTER_X: center[0] = longint'(signed'(data));
      REG_CENTER_Y: center[1] = longint'(signed'(data));
      REG_CENTER_Z: center[2] = longint'(signed'(data));
      default:      radius = longint'(data[30:0]);
    endcase
  endtask

  task automatic set_sphere(longint cx, longint cy, longint cz, longint r);
    write_reg(REG_CENTER_X, cx[31:0]);
    write_reg(REG_CENTER_Y, cy[31:0]);
    write_reg(REG_CENTER_Z, cz[31:0]);
    write_reg(REG_RADIUS, r[31:0]);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_ray(longint ox, longint oy, longint oz,
                          longint dx, longint dy, longint dz);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    ray_origin_x_i = ox[31:0];
    ray_origin_y_i = oy[31:0];
    ray_origin_z_i = oz[31:0];
    ray_dir_x_i = dx[31:0];
    ray_dir_y_i = dy[31:0];
    ray_dir_z_i = dz[31:0];
    in_valid_i = 1'b1;
    #1;
    while (!in_ready_o) begin
      @(negedge clk_i);
      #1;
    end
    @(negedge clk_i);
  endtask

  function automatic longint rand_word();
    return longint'(signed'(32'($urandom())));
  endfunction

  function automatic longint clip(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // one random ray: mostly aimed at the sphere, the rest noise and corner cases
  task automatic send_random_ray();
    longint o [3];
    longint d [3];
    longint span;
    int     kind;
    kind = $urandom_range(99);
    for (int i = 0; i < 3; i++) o[i] = rand_word();
    if (kind < 60) begin
      span = (radius < 64'sd2) ? 64'sd2 : radius;
      if ($urandom_range(3) == 0)
        for (int i = 0; i < 3; i++) o[i] = clip(center[i] + rand_word() / 256);
      for (int i = 0; i < 3; i++)
        d[i] = clip(center[i] + longint'($urandom_range(2 * 32'(span / 2))) - span / 2) - o[i];
      while (d[0] > 64'sd2147483647 || d[0] < -64'sd2147483648 ||
             d[1] > 64'sd2147483647 || d[1] < -64'sd2147483648 ||
             d[2] > 64'sd2147483647 || d[2] < -64'sd2147483648)
        for (int i = 0; i < 3; i++) d[i] = d[i] >>> 1;
    end else if (kind < 80) begin
      for (int i = 0; i < 3; i++) d[i] = rand_word();
    end else if (kind < 90) begin
      for (int i = 0; i < 3; i++) d[i] = longint'($urandom_range(64)) - 32;
    end else if (kind < 95) begin
      for (int i = 0; i < 3; i++) d[i] = 0;
    end else begin
      for (int i = 0; i < 3; i++)
        case ($urandom_range(3))
          0: d[i] = -64'sd2147483648;
          1: d[i] = 64'sd2147483647;
          2: d[i] = 64'sd1 <<< $urandom_range(30);
          default: d[i] = 0;
        endcase
    end
    send_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    for (int i = 0; i < 4; i++) @(negedge clk_i);
  endtask

  // one phase: random rays under each idling mode in turn
  task automatic run_phase(int count);
    for (int i = 0; i < count; i++) begin
      case ((i * 5) / count)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 84; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 84; end
        3: begin idle_pct = 15; stall_pct = 15; end
        default: begin idle_pct = $urandom_range(30); stall_pct = $urandom_range(30); end
      endcase
      send_random_ray();
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed rays against the unit sphere at the origin
    send_ray(0, 0, -5 * ONE, 0, 0, ONE);
    send_ray(0, 0, 5 * ONE, 0, 0, -ONE);
    send_ray(ONE, 0, -5 * ONE, 0, 0, ONE);          // tangent line
    send_ray(ONE + 1, 0, -5 * ONE, 0, 0, ONE);      // just outside
    send_ray(0, 0, 0, ONE, ONE, ONE);               // origin inside
    send_ray(3 * ONE, 0, 0, 0, 0, 0);               // zero direction
    send_ray(0, 0, 0, 1, 0, 0);                     // tiny direction
    send_ray(0, 0, -5 * ONE, 0, 0, -64'sd2147483648);
    send_ray(0, 0, -5 * ONE, 64'sd2147483647, 64'sd2147483647, 64'sd2147483647);
    send_ray(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648, 1, 1, 1);
    send_ray(64'sd2147483647, 64'sd2147483647, 64'sd2147483647, -1, -1, -1);
    send_ray(64'sd2147483647, 0, 0, -64'sd2147483648, 0, 0);
    send_ray(0, ONE / 2, -2 * ONE, 0, 0, 3);
    send_ray(-1, -1, -1, -64'sd2147483648, -64'sd2147483648, -64'sd2147483648);
    send_ray(0, 0, 0, 0, 0, 0);
    drain();

    // pressure: long hold-off while requests keep coming
    hold_req = 1'b1;
    idle_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < 180; i++) send_random_ray();
    drain();

    run_phase(80);

    set_sphere(10 * ONE, -3 * ONE, 7 * ONE, 10 * ONE);
    run_phase(70);

    set_sphere(64'sd2147483647, -64'sd2147483648, 64'sd2147483647, 64'sd2147483647);
    run_phase(50);

    set_sphere(-64'sd2147483648, 0, -64'sd2147483648, 0);
    run_phase(35);

    set_sphere(rand_word(), rand_word(), rand_word(), longint'($urandom_range(32'h7fffffff)));
    run_phase(60);

    set_sphere(rand_word() / 65536, rand_word() / 65536, rand_word() / 65536,
               longint'($urandom_range(1, 64 * 65536)));
    run_phase(60);

    for (int i = 0; i < 200; i++) @(negedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("ray_sphere_near_intersection test passed");
    else
      $display("ray_sphere_near_intersection test failed");
    $finish;
  end

endmodule
